// ----- rtl/fpa_pkg.sv -----
// shared types and constants for the q24.8 fixed-point alu
// no dependencies
`timescale 1ns / 1ps

package fpa_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int DATA_W        = 32;
  localparam int DIV_STEPS     = 8;
  localparam int DIV_STAGES    = (DATA_W + FRACTION_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_W         = DIV_STAGES * DIV_STEPS;

  typedef enum logic [3:0] {
    MODE_ADD        = 4'd0,
    MODE_SUB        = 4'd1,
    MODE_MUL        = 4'd2,
    MODE_DIV        = 4'd3,
    MODE_MIN        = 4'd4,
    MODE_MAX        = 4'd5,
    MODE_INC        = 4'd6,
    MODE_DEC        = 4'd7,
    MODE_INT_TO_FIX = 4'd8,
    MODE_FIX_TO_INT = 4'd9
  } fpa_mode_t;

  // data that rides alongside the divider
  typedef struct packed {
    logic [3:0]        mode;
    logic [DATA_W-1:0] res;
    logic              neg;
    logic              b_zero;
    logic              lt;
    logic              eq;
    logic              gt;
  } fpa_side_t;

  // divider working set: numerator bits shift out as quotient bits shift in
  typedef struct packed {
    logic [DIV_W-1:0]  nq;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] mb;
  } fpa_div_t;

endpackage

// ----- rtl/fpa_if.sv -----
// valid/ready channel interfaces for the fixed-point alu
// depends on fpa_pkg
`timescale 1ns / 1ps

interface fpa_in_if import fpa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [3:0]               mode;
  logic signed [DATA_W-1:0] operand_a;
  logic signed [DATA_W-1:0] operand_b;

  modport source (output valid, mode, operand_a, operand_b, input ready);
  modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if import fpa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic                     a_less;
  logic                     a_equal;
  logic                     a_greater;
  logic                     divide_error;

  modport source (output valid, result_value, a_less, a_equal, a_greater, divide_error,
                  input ready);
  modport sink   (input valid, result_value, a_less, a_equal, a_greater, divide_error,
                  output ready);
endinterface

// ----- rtl/fpa_front.sv -----
// first pipeline stage: simple results, compare flags, product, divider setup
// depends on fpa_pkg
`timescale 1ns / 1ps

module fpa_front import fpa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [3:0]               mode,
  input  logic signed [DATA_W-1:0] operand_a,
  input  logic signed [DATA_W-1:0] operand_b,
  output logic                     out_valid,
  output fpa_side_t                out_side,
  output logic signed [2*DATA_W-1:0] out_prod,
  output fpa_div_t                 out_div
);

  fpa_side_t         side_next;
  fpa_div_t          div_next;
  logic [DATA_W-1:0] ma;
  logic [DATA_W-1:0] mb;
  logic              lt;

  always_comb begin
    lt = operand_a < operand_b;
    ma = operand_a[DATA_W-1] ? DATA_W'(-operand_a) : DATA_W'(operand_a);
    mb = operand_b[DATA_W-1] ? DATA_W'(-operand_b) : DATA_W'(operand_b);

    side_next.mode   = mode;
    side_next.neg    = operand_a[DATA_W-1] ^ operand_b[DATA_W-1];
    side_next.b_zero = operand_b == '0;
    side_next.lt     = lt;
    side_next.eq     = operand_a == operand_b;
    side_next.gt     = operand_a > operand_b;
    case (mode)
      MODE_ADD:        side_next.res = operand_a + operand_b;
      MODE_SUB:        side_next.res = operand_a - operand_b;
      MODE_MIN:        side_next.res = lt ? operand_a : operand_b;
      MODE_MAX:        side_next.res = (operand_a > operand_b) ? operand_a : operand_b;
      MODE_INC:        side_next.res = operand_a + DATA_W'(1);
      MODE_DEC:        side_next.res = operand_a - DATA_W'(1);
      MODE_INT_TO_FIX: side_next.res = operand_a << FRACTION_BITS;
      MODE_FIX_TO_INT: side_next.res = operand_a >>> FRACTION_BITS;
      default:         side_next.res = '0;
    endcase

    div_next.nq  = DIV_W'(ma) << FRACTION_BITS;
    div_next.rem = '0;
    div_next.mb  = mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= side_next;
      out_prod <= operand_a * operand_b;
      out_div  <= div_next;
    end
  end

endmodule

// ----- rtl/fpa_div_stage.sv -----
// one divider stage: a group of restoring division steps, then a register
// depends on fpa_pkg
`timescale 1ns / 1ps

module fpa_div_stage import fpa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  fpa_side_t in_side,
  input  fpa_div_t  in_div,
  output logic      out_valid,
  output fpa_side_t out_side,
  output fpa_div_t  out_div
);

  fpa_div_t div_next;

  always_comb begin
    logic [DATA_W:0] rem_sh;
    div_next = in_div;
    for (int i = 0; i < DIV_STEPS; i++) begin
      rem_sh      = {div_next.rem, div_next.nq[DIV_W-1]};
      div_next.nq = {div_next.nq[DIV_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, div_next.mb}) begin
        rem_sh         = rem_sh - {1'b0, div_next.mb};
        div_next.nq[0] = 1'b1;
      end
      // remainder stays below the divisor, so the top bit is clear
      div_next.rem = rem_sh[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= in_side;
      out_div  <= div_next;
    end
  end

endmodule

// ----- rtl/fpa_post.sv -----
// last two stages: quotient rounding, then saturation and the output register
// depends on fpa_pkg
`timescale 1ns / 1ps

module fpa_post import fpa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  fpa_side_t                in_side,
  input  fpa_div_t                 in_div,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] result_value,
  output logic                     a_less,
  output logic                     a_equal,
  output logic                     a_greater,
  output logic                     divide_error
);

  localparam logic [DIV_W-1:0] POS_MAX = DIV_W'({1'b0, {(DATA_W-1){1'b1}}});
  localparam logic [DIV_W-1:0] NEG_MAX = DIV_W'({1'b1, {(DATA_W-1){1'b0}}});

  logic             rnd_valid;
  fpa_side_t        rnd_side;
  logic [DIV_W-1:0] rnd_q;
  logic             round_up;

  logic [DATA_W-1:0] quot;
  logic [DATA_W-1:0] res_next;
  logic              is_div;

  // round half away from zero on the magnitude
  assign round_up = {in_div.rem, 1'b0} >= {1'b0, in_div.mb};

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      rnd_valid <= in_valid;
      out_valid <= rnd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rnd_side <= in_side;
      rnd_q    <= in_div.nq + DIV_W'(round_up);
    end
  end

  always_comb begin
    if (rnd_side.neg) begin
      quot = (rnd_q > NEG_MAX) ? NEG_MAX[DATA_W-1:0] : DATA_W'(-rnd_q);
    end else begin
      quot = (rnd_q > POS_MAX) ? POS_MAX[DATA_W-1:0] : rnd_q[DATA_W-1:0];
    end
    is_div = rnd_side.mode == MODE_DIV;
    if (is_div) begin
      res_next = rnd_side.b_zero ? '0 : quot;
    end else begin
      res_next = rnd_side.res;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_value <= res_next;
      a_less       <= rnd_side.lt;
      a_equal      <= rnd_side.eq;
      a_greater    <= rnd_side.gt;
      divide_error <= is_div && rnd_side.b_zero;
    end
  end

endmodule

// ----- rtl/fixed_point_q24_8_alu.sv -----
// signed q24.8 fixed-point alu, top level
// depends on fpa_pkg, fpa_if, fpa_front, fpa_div_stage, fpa_post
`timescale 1ns / 1ps

// request carries mode, operand_a and operand_b; response carries the result
// value, the signed compare flags of a against b and the divide error flag.
// every item gives exactly one response, in order.
// the block is a fixed pipeline: one front stage (simple ops, compare, the
// 32x32 multiply), five divider stages of eight restoring steps each, one
// rounding stage and the output register, and every mode passes through all of
// them; a new item is taken every cycle while a full output is not stalled.
// the whole pipeline advances together: it moves whenever the output
// register is empty or its result is taken, so while the receiver stalls a
// full output, request.ready drops and every stage holds its contents.
// synchronous reset clears all stage valid bits; nothing else needs clearing.
module fixed_point_q24_8_alu import fpa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  fpa_in_if.sink    request,
  fpa_out_if.source response
);

  logic en;

  logic                       f_valid;
  fpa_side_t                  f_side;
  logic signed [2*DATA_W-1:0] f_prod;
  fpa_div_t                   f_div;
  fpa_side_t                  f_side_mul;

  logic      d_valid [DIV_STAGES+1];
  fpa_side_t d_side  [DIV_STAGES+1];
  fpa_div_t  d_div   [DIV_STAGES+1];

  assign en            = !response.valid || response.ready;
  assign request.ready = en;

  fpa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (request.valid),
    .mode      (request.mode),
    .operand_a (request.operand_a),
    .operand_b (request.operand_b),
    .out_valid (f_valid),
    .out_side  (f_side),
    .out_prod  (f_prod),
    .out_div   (f_div)
  );

  // product scaled back to q24.8 and wrapped
  always_comb begin
    f_side_mul = f_side;
    if (f_side.mode == MODE_MUL) begin
      f_side_mul.res = f_prod[FRACTION_BITS +: DATA_W];
    end
  end

  assign d_valid[0] = f_valid;
  assign d_side[0]  = f_side_mul;
  assign d_div[0]   = f_div;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    fpa_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (d_valid[s]),
      .in_side   (d_side[s]),
      .in_div    (d_div[s]),
      .out_valid (d_valid[s+1]),
      .out_side  (d_side[s+1]),
      .out_div   (d_div[s+1])
    );
  end

  fpa_post u_post (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (d_valid[DIV_STAGES]),
    .in_side      (d_side[DIV_STAGES]),
    .in_div       (d_div[DIV_STAGES]),
    .out_valid    (response.valid),
    .result_value (response.result_value),
    .a_less       (response.a_less),
    .a_equal      (response.a_equal),
    .a_greater    (response.a_greater),
    .divide_error (response.divide_error)
  );

endmodule

// ----- rtl/fpa_checker.sv -----
// port-level checks for the fixed-point alu, bound to the top level
// depends on fpa_pkg and fixed_point_q24_8_alu
`timescale 1ns / 1ps

module fpa_checker import fpa_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [DATA_W-1:0] result_value,
  input logic              a_less,
  input logic              a_equal,
  input logic              a_greater,
  input logic              divide_error
);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_value))
    else $error("response changed while stalled");

  // exactly one compare flag per result
  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> $countones({a_less, a_equal, a_greater}) == 1)
    else $error("compare flags not exclusive");

  // divide by zero gives zero
  a_div_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && divide_error |-> result_value == '0)
    else $error("divide error with nonzero result");

  // the input is held off exactly while a full output is stalled
  a_backpress: assert property (@(posedge clk) disable iff (rst)
    req_ready == (!rsp_valid || rsp_ready))
    else $error("request ready does not follow output stall");

endmodule

bind fixed_point_q24_8_alu fpa_checker u_fpa_checker (
  .clk          (clk),
  .rst          (rst),
  .req_ready    (request.ready),
  .rsp_valid    (response.valid),
  .rsp_ready    (response.ready),
  .result_value (response.result_value),
  .a_less       (response.a_less),
  .a_equal      (response.a_equal),
  .a_greater    (response.a_greater),
  .divide_error (response.divide_error)
);
